// File: hw/rtl/tvr_pkg.sv
// Package for the TMDS video receiver: period codes, symbol constants,
// timing and queue record types, and the TMDS decode helpers.
// No dependencies.
`timescale 1ns / 1ps

package tvr_pkg;

  // Link period codes as reported on period_now.
  typedef enum logic [2:0] {
    PER_VGUARD = 3'd0,
    PER_VIDEO  = 3'd1,
    PER_CTL    = 3'd2,
    PER_DGUARD = 3'd3,
    PER_ISLAND = 3'd4,
    PER_LOST   = 3'd5
  } period_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ACTIVE_WIDTH  = 3'd0,
    REG_ACTIVE_HEIGHT = 3'd1,
    REG_HSYNC_PIXELS  = 3'd2,
    REG_H_BACK_PORCH  = 3'd3,
    REG_LINE_TOTAL    = 3'd4,
    REG_VSYNC_LINES   = 3'd5,
    REG_V_BACK_PORCH  = 3'd6,
    REG_FRAME_LINES   = 3'd7
  } reg_idx_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

  localparam int CFG_DATA_W = 12;
  localparam int DIV_STEPS  = 24;

  // Guard band, control and TERC4 symbols (bit-reversed wire order).
  localparam logic [9:0] SYM_GUARD_A = 10'h2cc;
  localparam logic [9:0] SYM_GUARD_B = 10'h133;
  localparam logic [9:0] SYM_CTL_0   = 10'h354;
  localparam logic [9:0] SYM_CTL_1   = 10'h0ab;
  localparam logic [9:0] SYM_CTL_2   = 10'h154;
  localparam logic [9:0] SYM_CTL_3   = 10'h2ab;
  localparam logic [9:0] SYM_TERC_12 = 10'h28e;
  localparam logic [9:0] SYM_TERC_13 = 10'h271;
  localparam logic [9:0] SYM_TERC_14 = 10'h163;
  localparam logic [9:0] SYM_TERC_15 = 10'h2c3;
  localparam logic [9:0] COL_XOR_INV = 10'h3fc;
  localparam logic [9:0] COL_XOR_XNR = 10'h1fc;

  // Mode timing held in registers, with products registered from it.
  typedef struct packed {
    logic [11:0] active_width;
    logic [11:0] active_height;
    logic [9:0]  hsync_pixels;
    logic [9:0]  h_back_porch;
    logic [11:0] line_total;
    logic [7:0]  vsync_lines;
    logic [7:0]  v_back_porch;
    logic [10:0] frame_lines;
    logic [22:0] frame_size;
    logic [22:0] vlim;
  } timing_t;

  // One beat after the front end, waiting for the row computation.
  typedef struct packed {
    logic        cand;
    logic        x_ok;
    logic [11:0] x_pos;
    logic [22:0] frame;
    logic [11:0] column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        hs;
    logic        vs;
    logic [2:0]  period;
    logic        oos;
    logic        fstart;
    logic        err;
  } rec_t;

  function automatic logic [9:0] rev10(input logic [9:0] v);
    logic [9:0] r;
    for (int k = 0; k < 10; k++) begin
      r[k] = v[9-k];
    end
    return r;
  endfunction

  function automatic logic is_guard(input logic [9:0] v);
    return (v == SYM_GUARD_A) || (v == SYM_GUARD_B);
  endfunction

  // TMDS 8-bit data decode of one raw word.
  function automatic logic [7:0] colour(input logic [9:0] w);
    logic [9:0] m;
    logic [7:0] c;
    m = w;
    if (m[0]) begin
      m = m ^ COL_XOR_INV;
    end
    m = m ^ (m >> 1);
    if (!w[1]) begin
      m = m ^ COL_XOR_XNR;
    end
    for (int j = 0; j < 8; j++) begin
      c[j] = m[9-j];
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/tvr_if.sv
// Stream interfaces of the TMDS video receiver: symbol input and result output.
// No dependencies.
`timescale 1ns / 1ps

interface tvr_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] blue_word;
  logic [9:0] green_word;
  logic [9:0] red_word;

  modport source (output valid, output blue_word, output green_word, output red_word,
                  input ready);
  modport sink (input valid, input blue_word, input green_word, input red_word,
                output ready);
endinterface

interface tvr_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  red_value;
  logic [7:0]  green_value;
  logic [7:0]  blue_value;
  logic        hsync_level;
  logic        vsync_level;
  logic [2:0]  period_now;
  logic        sync_lost;
  logic        frame_start;
  logic        bounds_error;

  modport source (output valid, output pixel_valid, output pos_x, output pos_y,
                  output red_value, output green_value, output blue_value,
                  output hsync_level, output vsync_level, output period_now,
                  output sync_lost, output frame_start, output bounds_error,
                  input ready);
  modport sink (input valid, input pixel_valid, input pos_x, input pos_y,
                input red_value, input green_value, input blue_value,
                input hsync_level, input vsync_level, input period_now,
                input sync_lost, input frame_start, input bounds_error,
                output ready);
endinterface

// File: hw/rtl/tvr_front.sv
// Front end: accepts symbol beats, decodes them, tracks period and counters.
// Depends on tvr_pkg and tvr_in_if.
`timescale 1ns / 1ps

module tvr_front
  import tvr_pkg::*;
#(
  parameter int COLOR_BITS = 8,
  parameter int ISLAND_LEN = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  tvr_in_if.sink  in_if,
  input  timing_t tim,
  input  logic    q_full,
  output logic    push,
  output rec_t    rec
);

  localparam logic [6:0] ISL_MAX = 7'(ISLAND_LEN);

  period_t     period_r, period_nxt;
  logic [6:0]  pcnt_r, pcnt_nxt;
  logic [11:0] col_r, col_nxt;
  logic [22:0] frm_r, frm_nxt;
  logic        oos_r, oos_nxt;
  logic        phs_r, phs_nxt;
  logic        pvs_r, pvs_nxt;

  logic [9:0]  bb, bg, br;
  logic        vguard, dguard, s_ok, hs, vs, fstart, err;
  logic [1:0]  s_code;
  logic [9:0]  hlim;
  logic [10:0] h_start;
  logic [12:0] x_diff;
  logic [13:0] vid_end;

  assign in_if.ready = !q_full;
  assign push = in_if.valid && !q_full;

  // Decode the symbol triple and update link state.
  always_comb begin
    bb = rev10(in_if.blue_word);
    bg = rev10(in_if.green_word);
    br = rev10(in_if.red_word);
    vguard = is_guard(bb) && is_guard(bg) && is_guard(br) && (bb == br) && (bb != bg);
    dguard = ((bb == SYM_TERC_12) || (bb == SYM_TERC_13) || (bb == SYM_TERC_14) ||
              (bb == SYM_TERC_15)) && is_guard(bg) && is_guard(br);
    s_ok = 1'b1;
    s_code = 2'd0;
    case (bb)
      SYM_CTL_0: s_code = 2'd0;
      SYM_CTL_1: s_code = 2'd1;
      SYM_CTL_2: s_code = 2'd2;
      SYM_CTL_3: s_code = 2'd3;
      default:   s_ok = 1'b0;
    endcase
    hs = s_ok && s_code[0];
    vs = s_ok && s_code[1];

    period_nxt = period_r;
    pcnt_nxt = pcnt_r;
    col_nxt = col_r;
    frm_nxt = frm_r;
    oos_nxt = oos_r;
    fstart = 1'b0;
    err = 1'b0;
    h_start = {1'b0, tim.hsync_pixels} + {1'b0, tim.h_back_porch};

    // Period tracking.
    if (vguard) begin
      if (period_r != PER_VGUARD) begin
        period_nxt = PER_VGUARD;
        pcnt_nxt = '0;
      end else if (pcnt_r < ISL_MAX) begin
        pcnt_nxt = pcnt_r + 7'd1;
      end
      hs = 1'b0;
      vs = 1'b0;
    end else begin
      case (period_r)
        PER_VIDEO: begin
          hs = 1'b0;
          vs = 1'b0;
          if (pcnt_r < ISL_MAX) pcnt_nxt = pcnt_r + 7'd1;
        end
        PER_CTL: begin
          if (!s_ok) begin
            period_nxt = PER_LOST;
            oos_nxt = 1'b1;
          end else if (dguard) begin
            period_nxt = PER_DGUARD;
            pcnt_nxt = '0;
          end else if (pcnt_r < ISL_MAX) begin
            pcnt_nxt = pcnt_r + 7'd1;
          end
        end
        PER_DGUARD: begin
          if (!dguard) begin
            period_nxt = PER_ISLAND;
            pcnt_nxt = '0;
          end else if (pcnt_r < ISL_MAX) begin
            pcnt_nxt = pcnt_r + 7'd1;
          end
        end
        PER_ISLAND: begin
          if (pcnt_r >= ISL_MAX) begin
            if (dguard) period_nxt = PER_DGUARD;
            else oos_nxt = 1'b1;
            pcnt_nxt = '0;
          end else begin
            pcnt_nxt = pcnt_r + 7'd1;
          end
        end
        PER_VGUARD: begin
          period_nxt = PER_VIDEO;
          pcnt_nxt = '0;
          hs = 1'b0;
          vs = 1'b0;
          col_nxt = {1'b0, h_start} - 12'd1;
        end
        default: begin
          oos_nxt = 1'b1;
        end
      endcase
    end

    // Vertical sync: frame clock counter.
    if (vs && !pvs_r) begin
      fstart = 1'b1;
      frm_nxt = '0;
      oos_nxt = 1'b0;
    end else if (vs) begin
      if (frm_nxt < tim.vlim) begin
        frm_nxt = frm_nxt + 23'd1;
      end else begin
        oos_nxt = 1'b1;
        frm_nxt = tim.vlim;
      end
    end else begin
      frm_nxt = frm_nxt + 23'd1;
    end

    // Horizontal sync: column counter.
    hlim = (tim.hsync_pixels != '0) ? tim.hsync_pixels - 10'd1 : '0;
    if (hs && !phs_r) begin
      if ({1'b0, col_nxt} != ({1'b0, tim.line_total} - 13'd1)) oos_nxt = 1'b1;
      col_nxt = '0;
    end else if (hs) begin
      if (col_nxt < {2'b0, hlim}) begin
        col_nxt = col_nxt + 12'd1;
      end else begin
        col_nxt = {2'b0, hlim};
        if (!oos_nxt) begin
          frm_nxt = '0;
          oos_nxt = 1'b1;
        end
      end
    end else begin
      col_nxt = col_nxt + 12'd1;
    end

    // Bounds checks against the mode.
    if (frm_nxt >= tim.frame_size) err = 1'b1;
    if (hs && (col_nxt >= {2'b0, tim.hsync_pixels})) err = 1'b1;
    if (col_nxt >= tim.line_total) err = 1'b1;
    if (err) begin
      oos_nxt = 1'b1;
      col_nxt = '0;
      frm_nxt = '0;
    end

    // End of the active video run.
    vid_end = {2'b0, tim.active_width} + {3'b0, h_start};
    if ((period_nxt == PER_VIDEO) && ({2'b0, col_nxt} > vid_end)) begin
      period_nxt = PER_CTL;
      pcnt_nxt = '0;
    end

    phs_nxt = hs;
    pvs_nxt = vs;

    x_diff = {1'b0, col_nxt} - {2'b0, h_start};

    rec.cand = !err && !oos_nxt;
    rec.x_ok = !x_diff[12] && (x_diff[11:0] < tim.active_width);
    rec.x_pos = x_diff[11:0];
    rec.frame = frm_nxt;
    rec.column = col_nxt;
    rec.red = 8'(colour(in_if.red_word) << (8 - COLOR_BITS));
    rec.green = 8'(colour(in_if.green_word) << (8 - COLOR_BITS));
    rec.blue = 8'(colour(in_if.blue_word) << (8 - COLOR_BITS));
    rec.hs = hs;
    rec.vs = vs;
    rec.period = period_nxt;
    rec.oos = oos_nxt;
    rec.fstart = fstart;
    rec.err = err;
  end

  // State registers advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PER_CTL;
      pcnt_r <= '0;
      col_r <= '0;
      frm_r <= '0;
      oos_r <= 1'b0;
      phs_r <= 1'b0;
      pvs_r <= 1'b0;
    end else if (push) begin
      period_r <= period_nxt;
      pcnt_r <= pcnt_nxt;
      col_r <= col_nxt;
      frm_r <= frm_nxt;
      oos_r <= oos_nxt;
      phs_r <= phs_nxt;
      pvs_r <= pvs_nxt;
    end
  end

endmodule

// File: hw/rtl/tvr_queue.sv
// Two-entry queue between the front end and the row computation.
// Depends on tvr_pkg.
`timescale 1ns / 1ps

module tvr_queue
  import tvr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_data,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output rec_t head
);

  rec_t       mem [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head = mem[rd_r];

  // Pointer and fill count.
  always_comb begin
    wr_nxt = push ? !wr_r : wr_r;
    rd_nxt = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count missed a push");

endmodule

// File: hw/rtl/tvr_back.sv
// Back end: computes the visible row with a shared serial divider and
// holds the result beat until taken. Depends on tvr_pkg and tvr_out_if.
`timescale 1ns / 1ps

module tvr_back
  import tvr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  timing_t  tim,
  input  logic     q_not_empty,
  input  rec_t     q_head,
  output logic     pop,
  tvr_out_if.source out_if
);

  back_state_t state_r, state_nxt;
  rec_t        rec_r, rec_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [23:0] dvd_r, dvd_nxt;
  logic        neg_r, neg_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic [11:0] res_y_r, res_y_nxt;

  logic [23:0] diff;
  logic [12:0] rem_sh;
  logic        qbit;
  logic [23:0] quo;
  logic [25:0] y_val;

  // Sequencer and divider step.
  always_comb begin
    state_nxt = state_r;
    rec_nxt = rec_r;
    step_nxt = step_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    neg_nxt = neg_r;
    res_valid_nxt = res_valid_r;
    res_y_nxt = res_y_r;
    pop = 1'b0;

    diff = {1'b0, q_head.frame} - {12'b0, q_head.column};
    rem_sh = {rem_r[11:0], dvd_r[23]};
    qbit = (rem_sh >= {1'b0, tim.line_total});
    quo = {dvd_r[22:0], qbit};
    y_val = (neg_r ? -{2'b0, quo} : {2'b0, quo}) -
            ({18'b0, tim.v_back_porch} + {18'b0, tim.vsync_lines});

    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          pop = 1'b1;
          rec_nxt = q_head;
          neg_nxt = diff[23];
          dvd_nxt = diff[23] ? -diff : diff;
          rem_nxt = '0;
          step_nxt = '0;
          res_valid_nxt = 1'b0;
          res_y_nxt = '0;
          state_nxt = (q_head.cand && q_head.x_ok) ? BK_DIV : BK_OUT;
        end
      end
      BK_DIV: begin
        rem_nxt = qbit ? rem_sh - {1'b0, tim.line_total} : rem_sh;
        dvd_nxt = quo;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(DIV_STEPS - 1)) begin
          res_valid_nxt = !y_val[25] && (y_val[24:0] < {13'b0, tim.active_height});
          res_y_nxt = res_valid_nxt ? y_val[11:0] : '0;
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_if.ready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    step_r <= step_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    neg_r <= neg_nxt;
    res_valid_r <= res_valid_nxt;
    res_y_r <= res_y_nxt;
  end

  // Result beat.
  assign out_if.valid = (state_r == BK_OUT);
  assign out_if.pixel_valid = res_valid_r;
  assign out_if.pos_x = res_valid_r ? rec_r.x_pos : '0;
  assign out_if.pos_y = res_y_r;
  assign out_if.red_value = rec_r.red;
  assign out_if.green_value = rec_r.green;
  assign out_if.blue_value = rec_r.blue;
  assign out_if.hsync_level = rec_r.hs;
  assign out_if.vsync_level = rec_r.vs;
  assign out_if.period_now = rec_r.period;
  assign out_if.sync_lost = rec_r.oos;
  assign out_if.frame_start = rec_r.fstart;
  assign out_if.bounds_error = rec_r.err;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == BK_IDLE))
    else $error("queue popped while busy");
  a_valid_needs_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.pixel_valid) |-> (!rec_r.oos && !rec_r.err))
    else $error("pixel flagged while out of sync");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && step_r == 5'(DIV_STEPS - 1)) |=> (state_r == BK_OUT))
    else $error("divider did not finish");

endmodule

// File: hw/rtl/tvr_top_regs.sv
// Mode timing registers with the write port and registered derived products.
// Depends on tvr_pkg.
`timescale 1ns / 1ps

module tvr_top_regs
  import tvr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [2:0]            idx,
  input  logic [CFG_DATA_W-1:0] wdata,
  output timing_t               tim
);

  timing_t    tim_r, tim_nxt;
  logic [22:0] prod_f, prod_v;

  // Register writes and the two products used as limits, taken from the
  // values being written so that the limits change with the write.
  always_comb begin
    tim_nxt = tim_r;
    if (we) begin
      case (reg_idx_t'(idx))
        REG_ACTIVE_WIDTH:  tim_nxt.active_width = wdata;
        REG_ACTIVE_HEIGHT: tim_nxt.active_height = wdata;
        REG_HSYNC_PIXELS:  tim_nxt.hsync_pixels = wdata[9:0];
        REG_H_BACK_PORCH:  tim_nxt.h_back_porch = wdata[9:0];
        REG_LINE_TOTAL:    tim_nxt.line_total = wdata;
        REG_VSYNC_LINES:   tim_nxt.vsync_lines = wdata[7:0];
        REG_V_BACK_PORCH:  tim_nxt.v_back_porch = wdata[7:0];
        REG_FRAME_LINES:   tim_nxt.frame_lines = wdata[10:0];
        default: ;
      endcase
    end
    prod_f = 23'({11'b0, tim_nxt.line_total} * {12'b0, tim_nxt.frame_lines});
    prod_v = 23'({11'b0, tim_nxt.line_total} * {15'b0, tim_nxt.vsync_lines});
    tim_nxt.frame_size = prod_f;
    tim_nxt.vlim = (prod_v != '0) ? prod_v - 23'd1 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tim_r.active_width <= 12'd640;
      tim_r.active_height <= 12'd480;
      tim_r.hsync_pixels <= 10'd96;
      tim_r.h_back_porch <= 10'd48;
      tim_r.line_total <= 12'd800;
      tim_r.vsync_lines <= 8'd2;
      tim_r.v_back_porch <= 8'd33;
      tim_r.frame_lines <= 11'd525;
      tim_r.frame_size <= 23'd420000;
      tim_r.vlim <= 23'd1599;
    end else begin
      tim_r <= tim_nxt;
    end
  end

  assign tim = tim_r;

endmodule

// File: hw/rtl/tmds_video_receiver.sv
// Top level of the TMDS video receiver: timing registers, front end,
// queue and row-computing back end. Depends on tvr_pkg and tvr_if.
`timescale 1ns / 1ps
//
// Usage:
// in_if carries one beat per pixel clock: the blue, green and red 10-bit
// TMDS symbols. out_if returns exactly one result beat per input beat,
// in order: pixel flag and visible position, decoded colours, masked sync
// bits, link period, sync-lost, frame-start and bounds-error flags.
// cfg_we/cfg_index/cfg_wdata write the mode timing registers; write them
// only while no beat is in flight. Derived limits change with the write.
// The front end decodes and updates link state in the cycle a beat is
// accepted and pushes it into a two-entry queue. The back end computes the
// row with a serial divider, one quotient bit per cycle, for an in-sync
// beat inside the visible column range; other beats skip it, and no new
// beat is popped until the result is taken. An accepted beat is written
// into the queue, popped into the back end in BK_IDLE and presented from
// BK_OUT. If out_if.ready stays low the result holds, the queue fills and
// in_if.ready drops. Reset restores the default 640x480 timing, sets the
// link period to control and clears the front-end counters and the queue.

module tmds_video_receiver
  import tvr_pkg::*;
#(
  parameter int COLOR_BITS = 8,
  parameter int ISLAND_LEN = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tvr_in_if.sink                in_if,
  tvr_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  timing_t tim;
  rec_t    push_rec, head_rec;
  logic    push, pop, q_full, q_not_empty;

  tvr_top_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_index),
    .wdata (cfg_wdata),
    .tim   (tim)
  );

  tvr_front #(
    .COLOR_BITS (COLOR_BITS),
    .ISLAND_LEN (ISLAND_LEN)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .tim    (tim),
    .q_full (q_full),
    .push   (push),
    .rec    (push_rec)
  );

  tvr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_rec)
  );

  tvr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tim         (tim),
    .q_not_empty (q_not_empty),
    .q_head      (head_rec),
    .pop         (pop),
    .out_if      (out_if)
  );

endmodule
